// ===== design/sitda_pkg.sv =====
package sitda_pkg;

  localparam int MAG_W = 32;
  localparam int POS_W = 4;
  localparam int CHAR_W = 7;
  localparam int DIFF_W = MAG_W + 3;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 7'd57;
  localparam int RADIX_MAX_DIGIT = 9;

  // Queue between front and back
  localparam logic [1:0] Q_FULL_CNT = 2'd2;

  // One classified value: sign, magnitude and index of its leading digit
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [POS_W-1:0] pos;
  } item_t;

  function automatic logic [MAG_W-1:0] pow10(input logic [POS_W-1:0] k);
    logic [MAG_W-1:0] p;
    case (k)
      4'd0: p = 32'd1;
      4'd1: p = 32'd10;
      4'd2: p = 32'd100;
      4'd3: p = 32'd1000;
      4'd4: p = 32'd10000;
      4'd5: p = 32'd100000;
      4'd6: p = 32'd1000000;
      4'd7: p = 32'd10000000;
      4'd8: p = 32'd100000000;
      4'd9: p = 32'd1000000000;
      default: p = 32'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== design/sitda_front.sv =====
module sitda_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic [sitda_pkg::MAG_W-1:0] in_value,
  output logic                       in_full,
  output logic                       q_push,
  output sitda_pkg::item_t           q_item,
  input  logic                       q_full
);
  import sitda_pkg::*;

  logic             stage_v_r, stage_v_nxt;
  logic             stage_neg_r;
  logic [MAG_W-1:0] stage_mag_r;
  logic             load;
  logic [POS_W-1:0] lead_pos;

  assign in_full = stage_v_r & q_full;
  assign load = in_push & ~in_full;
  assign q_push = stage_v_r & ~q_full;
  assign stage_v_nxt = load | (stage_v_r & ~q_push);

  // Count the powers of ten the magnitude reaches: index of its leading digit
  always_comb begin
    lead_pos = '0;
    for (int k = 1; k <= RADIX_MAX_DIGIT; k++) begin
      if (stage_mag_r >= pow10(POS_W'(k))) begin
        lead_pos = lead_pos + POS_W'(1);
      end
    end
  end

  assign q_item.neg = stage_neg_r;
  assign q_item.mag = stage_mag_r;
  assign q_item.pos = lead_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
    if (load) begin
      stage_neg_r <= in_value[MAG_W-1];
      // Two's complement negate; the most negative value maps to 2^31
      stage_mag_r <= in_value[MAG_W-1] ? (MAG_W'(0) - in_value) : in_value;
    end
  end

endmodule

// ===== design/sitda_queue.sv =====
module sitda_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sitda_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output sitda_pkg::item_t head_item,
  output logic             empty
);
  import sitda_pkg::*;

  item_t      slot0_r, slot0_nxt;
  item_t      slot1_r, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] cnt_after_pop;
  logic       push_ok;
  logic       pop_ok;

  assign full = (cnt_r == Q_FULL_CNT);
  assign empty = (cnt_r == 2'd0);
  assign head_item = slot0_r;
  assign push_ok = push & ~full;
  assign pop_ok = pop & ~empty;
  assign cnt_after_pop = cnt_r - {1'b0, pop_ok};
  assign cnt_nxt = cnt_after_pop + {1'b0, push_ok};

  // Advance the tail slot into the head on pop, then drop the new item behind
  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (pop_ok) begin
      slot0_nxt = slot1_r;
    end
    if (push_ok) begin
      if (cnt_after_pop == 2'd0) begin
        slot0_nxt = push_item;
      end else begin
        slot1_nxt = push_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

// ===== design/sitda_back.sv =====
module sitda_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sitda_pkg::item_t             q_item,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [sitda_pkg::CHAR_W-1:0] out_character,
  output logic                         out_last
);
  import sitda_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DIGIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [MAG_W-1:0]  rem_r, rem_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              out_v_r, out_v_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic              gen_ok;
  logic              emit_v;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic [POS_W-1:0]  digit;
  logic [MAG_W-1:0]  rem_sel;
  logic [DIFF_W-1:0] cand;
  logic [DIFF_W-1:0] place;

  assign gen_ok = ~out_v_r | out_pop;
  assign place = {{(DIFF_W-MAG_W){1'b0}}, pow10(pos_r)};

  // Digit at the current place: largest multiple of the place value that fits
  always_comb begin
    digit = '0;
    rem_sel = rem_r;
    cand = '0;
    for (int d = 1; d <= RADIX_MAX_DIGIT; d++) begin
      cand = {{(DIFF_W-MAG_W){1'b0}}, rem_r} - DIFF_W'(d) * place;
      if (!cand[DIFF_W-1]) begin
        digit = POS_W'(d);
        rem_sel = cand[MAG_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt = rem_r;
    pos_nxt = pos_r;
    q_pop = 1'b0;
    emit_v = 1'b0;
    emit_char = CHAR_ZERO;
    emit_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty && gen_ok) begin
          // Load the item; a negative value leaves its sign in this cycle
          q_pop = 1'b1;
          rem_nxt = q_item.mag;
          pos_nxt = q_item.pos;
          emit_v = q_item.neg;
          emit_char = CHAR_MINUS;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (gen_ok) begin
          emit_v = 1'b1;
          emit_char = CHAR_ZERO + {{(CHAR_W-POS_W){1'b0}}, digit};
          emit_last = (pos_r == '0);
          rem_nxt = rem_sel;
          pos_nxt = pos_r - POS_W'(1);
          if (pos_r == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_v_nxt = emit_v | (out_v_r & ~out_pop);
  assign out_char_nxt = emit_v ? emit_char : out_char_r;
  assign out_last_nxt = emit_v ? emit_last : out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
    rem_r <= rem_nxt;
    pos_r <= pos_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_empty = ~out_v_r;
  assign out_character = out_char_r;
  assign out_last = out_last_r;

endmodule

// ===== design/signed_int_to_decimal_ascii_unit.sv =====
// Signed 32-bit integer to decimal ASCII text. Push a two's complement value
// on in_value; the block returns its decimal text one character per item on
// out_character, most significant digit first, with a leading '-' for a
// negative value, no leading zeros, a single '0' for zero, and out_last set
// on the final character (the most negative value prints as -2147483648).
// Each value passes the digit sequencer's load step, which also carries the
// minus sign, then one digit step per digit; the sequencer produces one digit
// per cycle while the output register has room. A value reaches the
// sequencer through a one-item input stage and a two-item queue, so new
// values keep being taken while earlier text is still going out, and the
// output register holds a character until pop and is refilled in the cycle
// it is popped, so characters leave one per cycle while pop stays high and
// the sequencer has one ready. A minus sign reaches the outputs through the
// input stage, a queue slot and the output register; a leading digit also
// passes the sequencer's state registers first. Reset needs no clearing pass.
module signed_int_to_decimal_ascii_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic signed [31:0]           in_value,
  output logic                         in_full,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [sitda_pkg::CHAR_W-1:0] out_character,
  output logic                         out_last
);
  import sitda_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  item_t q_in_item;
  item_t q_head_item;

  // Front: hold the value, take its magnitude and find its leading digit
  sitda_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_value (in_value),
    .in_full  (in_full),
    .q_push   (q_push),
    .q_item   (q_in_item),
    .q_full   (q_full)
  );

  // Decouple classification from character generation
  sitda_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (q_head_item),
    .empty     (q_empty)
  );

  // Back: emit the sign, then one digit per cycle while the output register has room, from the leading place down
  sitda_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_item        (q_head_item),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_character (out_character),
    .out_last      (out_last)
  );

`ifndef SYNTHESIS
  // Only a minus sign or a decimal digit ever leaves the block
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_character == CHAR_MINUS ||
                    (out_character >= CHAR_ZERO && out_character <= CHAR_NINE)))
    else $error("character outside sign and digit codes");

  // A sign always has at least one digit after it
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_character == CHAR_MINUS) |-> !out_last)
    else $error("minus sign marked as last character");

  // Input backpressure only when both the front stage and the queue are full
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> (q_full && !q_push))
    else $error("input stalled while queue had room");

  // The queue never hands out an item while it is empty
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sitda_pkg::*;

  // One character of expected decimal text
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  // Directed row: value and, where it is obvious, its text ("" means predict)
  typedef struct {
    logic [31:0] value;
    string       text;
  } dir_row_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_ROWS = 22;
  localparam int SEGMENTS = 8;
  localparam int SEG_ITEMS = 38;
  localparam int TAIL_CYCLES = 40;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic signed [31:0]  in_value = '0;
  logic                in_full;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic [CHAR_W-1:0]   out_character;
  logic                out_last;

  signed_int_to_decimal_ascii_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_value     (in_value),
    .in_full      (in_full),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_character(out_character),
    .out_last     (out_last)
  );

  // 8 ns period: low phase, then high phase
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_char_t expected_text[$];   // characters still owed by the block
  text_char_t head_char;
  text_char_t typed_char;
  string      cur_text;           // typed text of the item now on the inputs
  byte        text_byte;
  int         errors = 0;
  int         values_taken = 0;
  int         chars_checked = 0;
  int         negatives_taken = 0;
  int         full_runs = 0;
  int         cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         queued_before;
  dir_row_t   dir_rows [DIR_ROWS];

  // Append the decimal text of one value to the expected characters:
  // optional minus, then digits most significant first, last flag on the final one.
  function automatic void predict_text(input logic [31:0] v);
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  digs [0:9];
    int          n;
    text_char_t  tc;
    neg = v[31];
    mag = neg ? (32'd0 - v) : v;
    n = 0;
    do begin
      digs[n] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      n++;
    end while (mag != 32'd0 && n < 10);
    if (neg) begin
      tc.character = CHAR_MINUS;
      tc.last = 1'b0;
      expected_text.push_back(tc);
    end
    for (int i = n - 1; i >= 0; i--) begin
      tc.character = CHAR_ZERO + CHAR_W'(digs[i]);
      tc.last = (i == 0);
      expected_text.push_back(tc);
    end
  endfunction

  // Mix of full-range words, values of a chosen digit count, values around
  // powers of ten and tiny values, either sign.
  function automatic logic [31:0] pick_value();
    longint p10 [0:10];
    longint lo;
    longint hi;
    longint mag;
    int     k;
    logic   neg;
    p10[0] = 1;
    for (int i = 1; i <= 10; i++) p10[i] = p10[i-1] * 10;
    neg = 1'($urandom_range(1, 0));
    case ($urandom_range(3, 0))
      0: return $urandom;
      1: begin
        k = $urandom_range(10, 1);
        lo = (k == 1) ? 0 : p10[k-1];
        hi = p10[k] - 1;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        mag = longint'($urandom_range(32'(hi), 32'(lo)));
        if (neg && $urandom_range(15, 0) == 0) return 32'h8000_0000;
      end
      2: begin
        k = $urandom_range(9, 1);
        mag = p10[k] + $signed($urandom_range(2, 0)) - 1;
      end
      default: mag = longint'($urandom_range(20, 0));
    endcase
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 70; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      IDLE_BOTH: begin send_idle_pct = 22; recv_stall_pct = 22; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // Present one value, with random idle cycles first; hold until accepted.
  task automatic send_value(input logic [31:0] v, input string text);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_value = v;
    cur_text = text;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  // Hold the sender off until every owed character has come out.
  task automatic drain_text();
    in_push = 1'b0;
    while (expected_text.size() != 0) @(negedge clk);
  endtask

  // Receiver: decide pop for the next edge at each falling edge
  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Accepted value: record what it must print
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      values_taken++;
      if (in_value[31]) negatives_taken++;
      queued_before = expected_text.size();
      if (cur_text.len() > 0) begin
        for (int i = 0; i < cur_text.len(); i++) begin
          text_byte = cur_text[i];
          typed_char.character = text_byte[CHAR_W-1:0];
          typed_char.last = (i == cur_text.len() - 1);
          expected_text.push_back(typed_char);
        end
      end else begin
        predict_text(in_value);
      end
      if (expected_text.size() - queued_before == 11) full_runs++;
    end
  end

  // Accepted character: compare with the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_text.size() == 0) begin
        $error("unexpected item: character %0d last %0b", out_character, out_last);
        errors++;
      end else begin
        head_char = expected_text.pop_front();
        chars_checked++;
        if (out_character !== head_char.character) begin
          $error("character: expected %0d, got %0d", head_char.character, out_character);
          errors++;
        end
        if (out_last !== head_char.last) begin
          $error("last: expected %0b, got %0b", head_char.last, out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    // Extremes and digit-count boundaries are typed in; the rest is predicted.
    dir_rows = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{-32'sd1,        "-1"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{-32'sd10,       "-10"},
      '{32'h7FFF_FFFF,  "2147483647"},
      '{32'h8000_0000,  "-2147483648"},
      '{32'h8000_0001,  "-2147483647"},
      '{32'd1000000000, "1000000000"},
      '{-32'sd1000000000, "-1000000000"},
      '{32'd999999999,  "999999999"},
      '{32'd100,        ""},
      '{32'h5555_5555,  ""},
      '{32'hAAAA_AAAA,  ""},
      '{32'd123456789,  ""},
      '{-32'sd987654321, ""},
      '{32'hFFFF_0000,  ""},
      '{32'h0000_FFFF,  ""},
      '{32'd7,          ""},
      '{-32'sd100000,   ""},
      '{32'd1999999999, ""}
    };

    // Synchronous reset, released on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows, no idling on either side
    set_idling(IDLE_NONE);
    foreach (dir_rows[r]) send_value(dir_rows[r].value, dir_rows[r].text);
    drain_text();

    // Random values, cycling through the idling modes; drain between segments
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_idling(idle_mode_t'(seg % 4));
      for (int n = 0; n < SEG_ITEMS; n++) send_value(pick_value(), "");
      drain_text();
    end

    // Tail: keep popping so any stray character is caught
    set_idling(IDLE_NONE);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("tb: %0d values (%0d negative, %0d of full length) printed as %0d characters",
             values_taken, negatives_taken, full_runs, chars_checked);
    $display("tb: idling modes none, sender, receiver and both; %0d mismatches", errors);
    if (errors == 0 && expected_text.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
